// ===== rtl/core/ffa_pkg.sv =====
package ffa_pkg;

   localparam logic [2:0] OP_DIV = 3'd0;
   localparam logic [2:0] OP_MUL = 3'd1;
   localparam logic [2:0] OP_I2F = 3'd2;
   localparam logic [2:0] OP_F2I = 3'd3;
   localparam logic [2:0] OP_CMP = 3'd4;

   localparam logic [1:0] ORD_EQ    = 2'd0;
   localparam logic [1:0] ORD_BELOW = 2'd1;
   localparam logic [1:0] ORD_ABOVE = 2'd2;

   localparam int unsigned QUO_STEPS = 24;

   typedef struct packed {
      logic [2:0]  op;
      logic [31:0] operand_a;
      logic [31:0] operand_b;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] result_word;
      logic [1:0]  order;
   } rsp_payload_type;

   // One pipeline stage's worth of work in flight.
   typedef struct packed {
      logic [2:0]  op;
      logic        spec;
      logic        sgn;
      logic [7:0]  expo;
      logic [24:0] rem;
      logic [23:0] dvs;
      logic [23:0] quo;
      logic        rnd;
      logic [47:0] prod;
      logic [31:0] mag;
      logic [4:0]  lz;
      logic [31:0] word;
      logic [1:0]  order;
   } stage_type;

   // Restoring division steps first .. first+count-1; the step after the
   // last quotient bit only yields the round bit.
   function automatic stage_type div_steps(stage_type s, int unsigned first,
                                           int unsigned count);
      stage_type   r;
      logic        take;
      r = s;
      for (int unsigned i = 0; i < count; i++) begin
         take = (r.rem >= {1'b0, r.dvs});
         if (take) begin
            r.rem = r.rem - {1'b0, r.dvs};
         end
         if (first + i < QUO_STEPS) begin
            r.quo = {r.quo[22:0], take};
            r.rem = {r.rem[23:0], 1'b0};
         end else begin
            r.rnd = take;
         end
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/ffa_front.sv =====
module ffa_front (
   input  ffa_pkg::req_payload_type req,
   output ffa_pkg::stage_type       stg
);
   import ffa_pkg::*;

   logic [23:0] ma, mb;
   logic [7:0]  ea, eb;
   logic        a_zero, b_zero;
   logic [31:0] mag;
   logic [4:0]  lz;
   logic [8:0]  fsh;
   logic [31:0] fint;
   logic [1:0]  ord;

   assign ma     = {1'b1, req.operand_a[22:0]};
   assign mb     = {1'b1, req.operand_b[22:0]};
   assign ea     = req.operand_a[30:23];
   assign eb     = req.operand_b[30:23];
   assign a_zero = (req.operand_a[30:0] == 31'd0);
   assign b_zero = (req.operand_b[30:0] == 31'd0);

   // Magnitude and leading-zero count for integer to float.
   always_comb begin
      mag = req.operand_a[31] ? (32'd0 - req.operand_a) : req.operand_a;
      lz  = 5'd0;
      for (int i = 0; i < 32; i++) begin
         if (mag[i]) begin
            lz = 5'(31 - i);
         end
      end
   end

   // Float to integer; a shift code of zero stands for 256.
   always_comb begin
      fsh = {1'b0, ea - 8'd126};
      if (fsh == 9'd0) begin
         fsh = 9'd256;
      end
      if (fsh <= 9'd24) begin
         fint = {8'd0, ma} >> 5'(9'd24 - fsh);
      end else if (fsh < 9'd56) begin
         fint = {8'd0, ma} << 5'(fsh - 9'd24);
      end else begin
         fint = 32'd0;
      end
      if (req.operand_a[31]) begin
         fint = 32'd0 - fint;
      end
      if (a_zero) begin
         fint = 32'd0;
      end
   end

   always_comb begin
      if (req.operand_a[31] != req.operand_b[31]) begin
         ord = req.operand_a[31] ? ORD_BELOW : ORD_ABOVE;
      end else if (req.operand_a[30:0] == req.operand_b[30:0]) begin
         ord = ORD_EQ;
      end else if ((req.operand_a[30:0] < req.operand_b[30:0]) ^ req.operand_a[31]) begin
         ord = ORD_BELOW;
      end else begin
         ord = ORD_ABOVE;
      end
   end

   always_comb begin
      stg       = '0;
      stg.op    = req.op;
      stg.sgn   = req.operand_a[31] ^ req.operand_b[31];
      stg.rem   = {1'b0, ma};
      stg.dvs   = mb;
      stg.prod  = ma * mb;
      stg.mag   = mag;
      stg.lz    = lz;
      case (req.op)
         OP_DIV: begin
            stg.expo = ea - eb + 8'd127;
            if (b_zero) begin
               stg.spec = 1'b1;
               stg.word = '1;
            end else if (a_zero) begin
               stg.spec = 1'b1;
            end
         end
         OP_MUL: begin
            stg.expo = ea + eb - 8'd127;
            stg.spec = a_zero || b_zero;
         end
         OP_I2F: begin
            stg.expo = 8'd158 - {3'd0, lz};
            stg.sgn  = req.operand_a[31];
            stg.spec = (req.operand_a == 32'd0);
         end
         OP_F2I: begin
            stg.spec = 1'b1;
            stg.word = fint;
         end
         OP_CMP: begin
            stg.spec  = 1'b1;
            stg.order = ord;
         end
         default: begin
            stg.spec = 1'b1;
         end
      endcase
   end

endmodule

// ===== rtl/core/firmware_float_alu.sv =====
// Channel | Direction | Ports
// request | in        | req_valid, req_ready, req_payload (op, operand_a, operand_b)
// result  | out       | rsp_valid, rsp_ready, rsp_payload (result_word, order)
//
// Every operation passes the operand stage, four division stages and a rounding stage
// before its result is valid, and one may enter in every cycle while req_ready is
// high. The 25 restoring division steps are spread over the four stages after the
// operand stage. Reset clears the valid bits only. When a result beat waits, the
// whole pipeline holds and req_ready is low, so nothing is dropped or repeated.
module firmware_float_alu (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  ffa_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output ffa_pkg::rsp_payload_type rsp_payload
);
   import ffa_pkg::*;

   localparam int unsigned NSTG = 5;

   stage_type       front;
   stage_type       stage_ff [NSTG];
   stage_type       stage_in [NSTG];
   logic [NSTG-1:0] valid_ff, valid_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_ff, rsp_in;
   logic            adv;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   ffa_front u_front (
      .req (req_payload),
      .stg (front)
   );

   // Operand register from the front end; first stage after the operands: multiply
   // rounding, int to float shift and the first seven division steps; later stages: the remaining division steps.
   always_comb begin
      logic [24:0] hi;
      logic [23:0] h24;
      logic        rb;
      logic [24:0] sum;
      logic [7:0]  e;
      logic [31:0] sh;
      stage_in[0] = front;
      stage_in[1] = div_steps(stage_ff[0], 0, 7);
      hi  = stage_ff[0].prod[47:23];
      rb  = hi[24] ? stage_ff[0].prod[23] : stage_ff[0].prod[22];
      h24 = hi[24] ? hi[24:1] : hi[23:0];
      e   = stage_ff[0].expo + {7'd0, hi[24]};
      sum = {1'b0, h24} + {24'd0, rb};
      if (sum[24]) begin
         sum = {1'b0, sum[24:1]};
         e   = e + 8'd1;
      end
      sh = stage_ff[0].mag << stage_ff[0].lz;
      if (!stage_ff[0].spec) begin
         if (stage_ff[0].op == OP_MUL) begin
            stage_in[1].word = {stage_ff[0].sgn, e, sum[22:0]};
         end else if (stage_ff[0].op == OP_I2F) begin
            stage_in[1].word = {stage_ff[0].sgn, stage_ff[0].expo, sh[30:8]};
         end
      end
      stage_in[2] = div_steps(stage_ff[1], 7, 6);
      stage_in[3] = div_steps(stage_ff[2], 13, 6);
      stage_in[4] = div_steps(stage_ff[3], 19, 6);
   end

   // Quotient rounding and normalisation, and selection of the result word.
   always_comb begin
      logic [23:0] q;
      logic [24:0] q25;
      logic [7:0]  e;
      q   = stage_ff[4].quo;
      e   = stage_ff[4].expo;
      q25 = {1'b0, q} + 25'd1;
      if (stage_ff[4].rnd) begin
         if (q25[24]) begin
            q = q25[24:1];
            e = e + 8'd1;
         end else begin
            q = q25[23:0];
         end
      end
      if (!q[23]) begin
         q = {q[22:0], 1'b0};
         e = e - 8'd1;
      end
      rsp_in.order = stage_ff[4].order;
      if (stage_ff[4].op == OP_DIV && !stage_ff[4].spec) begin
         rsp_in.result_word = {stage_ff[4].sgn, e, q[22:0]};
      end else begin
         rsp_in.result_word = stage_ff[4].word;
      end
   end

   assign valid_in     = {valid_ff[NSTG-2:0], req_valid};
   assign rsp_valid_in = valid_ff[NSTG-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < NSTG; i++) begin
            stage_ff[i] <= stage_in[i];
         end
         rsp_ff <= rsp_in;
      end
   end

`ifndef SYNTHESIS
   a_stage_moves: assert property (@(posedge clock) disable iff (reset)
      valid_ff[0] && adv |=> valid_ff[1])
      else $error("pipeline lost a beat between stages");
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      valid_ff[NSTG-1] && !adv |=> valid_ff[NSTG-1] && $stable(stage_ff[NSTG-1]))
      else $error("last stage changed while stalled");
   a_order_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.order != 2'd3)
      else $error("invalid order code");
`endif

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;
   import ffa_pkg::*;

   // Golden arithmetic for one request beat.
   class fpu_scoreboard;
      rsp_payload_type pending[$];
      int unsigned     errors;

      function new();
         errors = 0;
      endfunction

      function automatic logic [31:0] divide(logic [31:0] a, logic [31:0] b);
         logic [24:0] rem;
         logic [24:0] dvs;
         logic [24:0] q;
         logic [7:0]  e;
         logic        rnd;
         q = '0;
         rnd = 1'b0;
         if (b[30:0] == 31'd0) return 32'hffff_ffff;
         if (a[30:0] == 31'd0) return 32'h0;
         rem = {2'b01, a[22:0]};
         dvs = {2'b01, b[22:0]};
         e = a[30:23] - b[30:23] + 8'd127;
         for (int k = 0; k < 25; k++) begin
            if (k < 24) begin
               q = {q[23:0], rem >= dvs};
               if (rem >= dvs) rem = rem - dvs;
               rem = {rem[23:0], 1'b0};
            end else begin
               rnd = rem >= dvs;
            end
         end
         if (rnd) begin
            q = q + 25'd1;
            if (q[24]) begin
               q = q >> 1;
               e = e + 8'd1;
            end
         end
         if (!q[23]) begin
            q = {q[23:0], 1'b0};
            e = e - 8'd1;
         end
         return {a[31] ^ b[31], e, q[22:0]};
      endfunction

      function automatic logic [31:0] multiply(logic [31:0] a, logic [31:0] b);
         logic [47:0] p;
         logic [31:0] hi;
         logic [31:0] lo;
         logic [7:0]  e;
         if (a[30:0] == 31'd0 || b[30:0] == 31'd0) return 32'h0;
         p = {24'd0, 1'b1, a[22:0]} * {24'd0, 1'b1, b[22:0]};
         hi = 32'(p >> 23);
         lo = {p[22:0], 9'd0};
         e = a[30:23] + b[30:23] - 8'd127;
         if (hi[24]) begin
            lo = {hi[0], lo[31:1]};
            hi = hi >> 1;
            e = e + 8'd1;
         end
         if (lo[31]) begin
            hi = hi + 32'd1;
            if (hi[24]) begin
               hi = hi >> 1;
               e = e + 8'd1;
            end
         end
         return {a[31] ^ b[31], e, hi[22:0]};
      endfunction

      function automatic logic [31:0] int_to_float(logic [31:0] v);
         logic [31:0] m;
         logic [7:0]  n;
         if (v == 32'd0) return 32'h0;
         m = v[31] ? -v : v;
         n = 8'd0;
         while (!m[31]) begin
            m = m << 1;
            n = n + 8'd1;
         end
         return {v[31], 8'd158 - n, m[30:8]};
      endfunction

      function automatic logic [31:0] float_to_int(logic [31:0] v);
         int unsigned n;
         logic [63:0] m;
         logic [31:0] r;
         if (v[30:0] == 31'd0) return 32'h0;
         n = 8'(v[30:23] - 8'd126);
         if (n == 0) n = 256;
         m = {40'd0, 1'b1, v[22:0]};
         r = '0;
         if (n <= 24) r = 32'(m >> (24 - n));
         else if (n < 56) r = 32'(m << (n - 24));
         return v[31] ? -r : r;
      endfunction

      function automatic logic [1:0] compare(logic [31:0] a, logic [31:0] b);
         if (a[31] != b[31]) return a[31] ? ORD_BELOW : ORD_ABOVE;
         if (a[30:0] == b[30:0]) return ORD_EQ;
         return ((a[30:0] < b[30:0]) ^ a[31]) ? ORD_BELOW : ORD_ABOVE;
      endfunction

      function void note_request(req_payload_type r);
         rsp_payload_type x;
         x = '0;
         case (r.op)
            OP_DIV: x.result_word = divide(r.operand_a, r.operand_b);
            OP_MUL: x.result_word = multiply(r.operand_a, r.operand_b);
            OP_I2F: x.result_word = int_to_float(r.operand_a);
            OP_F2I: x.result_word = float_to_int(r.operand_a);
            OP_CMP: x.order = compare(r.operand_a, r.operand_b);
            default: ;
         endcase
         pending.push_back(x);
      endfunction

      function void check_result(rsp_payload_type got);
         rsp_payload_type x;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result beat %h", $time, got);
            errors++;
            return;
         end
         x = pending.pop_front();
         if (got.result_word !== x.result_word) begin
            $display("%0t: result_word expected %h actual %h", $time, x.result_word,
                     got.result_word);
            errors++;
         end
         if (got.order !== x.order) begin
            $display("%0t: order expected %0d actual %0d", $time, x.order, got.order);
            errors++;
         end
      endfunction
   endclass

   logic            clock = 0;
   logic            reset = 1;
   logic            req_valid = 0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready = 0;
   rsp_payload_type rsp_payload;

   fpu_scoreboard scb = new();
   bit            quiet = 0;
   bit            stall_request = 0;
   bit            stall_taken = 0;
   int            hold_off = 0;

   always #6 clock = ~clock;

   firmware_float_alu i_dut (.*);

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) scb.note_request(req_payload);
         if (rsp_valid && rsp_ready) scb.check_result(rsp_payload);
      end
   end

   // Receiver stalls; a requested hold-off is counted here and honoured first.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
      end else if (stall_request && !stall_taken) begin
         stall_taken <= 1;
         hold_off    <= 199;
         rsp_ready   <= 0;
      end else if (hold_off > 0) begin
         rsp_ready <= 0;
         hold_off <= hold_off - 1;
      end else begin
         rsp_ready <= quiet || ($urandom_range(99) >= 6);
      end
   end

   function automatic logic [31:0] rand_float();
      logic [31:0] w;
      w = $urandom;
      case ($urandom_range(9)) inside
         0: w[30:0] = 0;
         [1:3]: w[30:23] = 8'd127 + 8'($urandom_range(40)) - 8'd20;
         default: ;
      endcase
      return w;
   endfunction

   // Valid stays high after a beat so that back-to-back beats need no second
   // assignment in one time step; idling or drain() lowers it.
   task automatic send(logic [2:0] op, logic [31:0] a, logic [31:0] b);
      while (!quiet && $urandom_range(99) < 6) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_payload <= '{op: op, operand_a: a, operand_b: b};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (scb.pending.size() != 0) @(negedge clock);
   endtask

   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

   initial begin
      logic [31:0] a;
      logic [31:0] b;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      send(OP_DIV, 32'h3f80_0000, 32'h0000_0000);
      send(OP_DIV, 32'h8000_0000, 32'h4000_0000);
      send(OP_DIV, 32'h0000_0000, 32'h8000_0000);
      send(OP_DIV, 32'h3f80_0000, 32'h4040_0000);
      send(OP_DIV, 32'hffff_ffff, 32'h7fff_ffff);
      send(OP_MUL, 32'h0000_0000, 32'h3f80_0000);
      send(OP_MUL, 32'h3f80_0000, 32'h8000_0000);
      send(OP_MUL, 32'h3fff_ffff, 32'hbfff_ffff);
      send(OP_MUL, 32'hffff_ffff, 32'hffff_ffff);
      send(OP_I2F, 32'h0000_0000, 0);
      send(OP_I2F, 32'h8000_0000, 0);
      send(OP_I2F, 32'h7fff_ffff, 0);
      send(OP_I2F, 32'hffff_ffff, 0);
      send(OP_F2I, 32'h8000_0000, 0);
      send(OP_F2I, 32'h3f00_0000, 0);
      send(OP_F2I, 32'h4f7f_ffff, 0);
      send(OP_F2I, 32'hcb7f_ffff, 0);
      send(OP_F2I, 32'h7fff_ffff, 0);
      send(OP_CMP, 32'h8000_0000, 32'h0000_0000);
      send(OP_CMP, 32'hbf80_0000, 32'hc000_0000);
      send(OP_CMP, 32'h3f80_0000, 32'h3f80_0000);
      send(OP_CMP, 32'h3f80_0000, 32'h4000_0000);
      send(3'd5, 32'hffff_ffff, 32'hffff_ffff);
      send(3'd7, 32'h1234_5678, 32'h0);
      // Sender waits for every outstanding result.
      drain();
      for (int i = 0; i < 1700; i++) begin
         quiet = (i >= 600 && i < 900);
         if (i == 1000) stall_request = 1;
         a = ($urandom_range(3) == 0) ? $urandom : rand_float();
         b = rand_float();
         send(3'($urandom_range(7)), a, b);
      end
      drain();
      repeat (20) @(negedge clock);
      if (scb.errors == 0 && scb.pending.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
